FILE: rtl/mrfr_pkg.sv
// Shared types and constants for the framed Manchester command receiver.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package mrfr_pkg;

   localparam int BYTE_W    = 8;
   localparam int LINE_NUM  = 4;
   localparam int CSR_IDX_W = 3;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SYNC    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRAILER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CODE1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CODE2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CODE3   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CODE4   = 3'd5;

   // CSR reset values
   localparam logic [BYTE_W-1:0] SYNC_RST    = 8'h55;
   localparam logic [BYTE_W-1:0] TRAILER_RST = 8'hAA;
   localparam logic [BYTE_W-1:0] CODE1_RST   = 8'h04;
   localparam logic [BYTE_W-1:0] CODE2_RST   = 8'h06;
   localparam logic [BYTE_W-1:0] CODE3_RST   = 8'h09;
   localparam logic [BYTE_W-1:0] CODE4_RST   = 8'h11;

   typedef struct packed {
      logic [BYTE_W-1:0]                sync;
      logic [BYTE_W-1:0]                trailer;
      logic [LINE_NUM-1:0][BYTE_W-1:0]  code;     // code[0] toggles line one
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   cmd;
      logic                ok;
      logic [LINE_NUM-1:0] toggle;
   } dec_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_HIGH  = 5'b00010,
      PH_LOW   = 5'b00100,
      PH_CHECK = 5'b01000,
      PH_TRAIL = 5'b10000
   } phase_type;

endpackage

FILE: rtl/mrfr_if.sv
// Valid/ready channel interfaces: received byte, decoded result, CSR write.
// Depends on mrfr_pkg.
`timescale 1ns / 1ps

interface mrfr_req_if import mrfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, rx_byte, input ready);
   modport sink   (input valid, rx_byte, output ready);
endinterface

interface mrfr_rsp_if import mrfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   command;
   logic                frame_ok;
   logic [LINE_NUM-1:0] line_levels;

   modport source (output valid, command, frame_ok, line_levels, input ready);
   modport sink   (input valid, command, frame_ok, line_levels, output ready);
endinterface

interface mrfr_csr_if import mrfr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [BYTE_W-1:0]    wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: rtl/mrfr_decode.sv
// Frame check and Manchester decode of the completed frame, combinational.
// Depends on mrfr_pkg.
`timescale 1ns / 1ps

module mrfr_decode import mrfr_pkg::*; (
   input  cfg_type           cfg,
   input  logic [BYTE_W-1:0] high_half,
   input  logic [BYTE_W-1:0] low_half,
   input  logic [BYTE_W-1:0] check_value,
   input  logic [BYTE_W-1:0] trailer,
   output dec_type           dec
);

   logic [2*BYTE_W-1:0] bits;
   logic [BYTE_W-1:0]   raw_cmd;
   logic                ok;

   assign bits = {high_half, low_half};
   assign ok   = ((high_half & low_half) == check_value) && (trailer == cfg.trailer);

   // MSB-first pairs: 01 -> 1, anything else -> 0
   always_comb begin
      for (int k = 0; k < BYTE_W; k++) begin
         raw_cmd[BYTE_W-1-k] = (bits[2*BYTE_W-1-2*k -: 2] == 2'b01);
      end
   end

   always_comb begin
      dec.ok  = ok;
      dec.cmd = ok ? raw_cmd : '0;
      for (int i = 0; i < LINE_NUM; i++) begin
         dec.toggle[i] = ok && (raw_cmd == cfg.code[i]);
      end
   end

endmodule

FILE: rtl/manchester_remote_frame_receiver.sv
// Top level of the framed Manchester command receiver.
// Depends on mrfr_pkg, mrfr_if (channel interfaces) and mrfr_decode.
`timescale 1ns / 1ps
//
//  channel | port   | dir | payload                              | transfer when
//  --------+--------+-----+--------------------------------------+----------------
//  request | req_ch | in  | rx_byte[7:0]                         | valid & ready
//  result  | rsp_ch | out | command[7:0] frame_ok line_levels[3:0]| valid & ready
//  csr     | csr_ch | in  | reg_index[2:0] wr_data[7:0]          | valid & ready
//
// One byte per cycle sustained unless the result register stalls. A byte
// lands in the input register and is consumed from it by the frame
// sequencer; the fifth byte of a frame, the trailer, loads the result
// register as it is consumed, and rsp valid is driven from that register.
// Only the result register can stall: if it is full and not taken, a trailer
// byte waits in the input register and req ready drops; other bytes keep
// flowing. Synchronous active-high reset restores CSR defaults, idles the
// sequencer and drives all lines low. csr ready is always high.

module manchester_remote_frame_receiver import mrfr_pkg::*; (
   input logic       clock,
   input logic       reset,
   mrfr_req_if.sink   req_ch,
   mrfr_rsp_if.source rsp_ch,
   mrfr_csr_if.sink   csr_ch
);

   // configuration
   cfg_type cfg_ff, cfg_in;

   // input register
   logic              s1_vld_ff, s1_vld_in;
   logic [BYTE_W-1:0] s1_byte_ff;

   // frame sequencer state
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] high_ff, low_ff, check_ff;
   logic [LINE_NUM-1:0] lines_ff, lines_in;

   // result register
   logic                rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0]   rsp_cmd_ff;
   logic                rsp_ok_ff;
   logic [LINE_NUM-1:0] rsp_lines_ff;

   logic    req_xfer, rsp_xfer, csr_xfer;
   logic    s1_done;   // input register holds the trailer byte
   logic    s1_adv;    // sequencer consumes the input register this cycle
   logic    load_rsp;
   dec_type dec;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;
   assign csr_xfer = csr_ch.valid && csr_ch.ready;

   assign csr_ch.ready = 1'b1;

   // ---------------- CSR writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_xfer) begin
         case (csr_ch.reg_index)
            REG_SYNC:    cfg_in.sync    = csr_ch.wr_data;
            REG_TRAILER: cfg_in.trailer = csr_ch.wr_data;
            REG_CODE1:   cfg_in.code[0] = csr_ch.wr_data;
            REG_CODE2:   cfg_in.code[1] = csr_ch.wr_data;
            REG_CODE3:   cfg_in.code[2] = csr_ch.wr_data;
            REG_CODE4:   cfg_in.code[3] = csr_ch.wr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   // ---------------- flow control
   assign s1_done  = s1_vld_ff && (phase_ff == PH_TRAIL);
   assign s1_adv   = s1_vld_ff && (!s1_done || !rsp_vld_ff || rsp_ch.ready);
   assign load_rsp = s1_done && s1_adv;

   assign req_ch.ready = !s1_vld_ff || s1_adv;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_xfer) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
   end

   // ---------------- frame check and decode
   mrfr_decode u_decode (
      .cfg         (cfg_ff),
      .high_half   (high_ff),
      .low_half    (low_ff),
      .check_value (check_ff),
      .trailer     (s1_byte_ff),
      .dec         (dec)
   );

   // ---------------- sequencer; a sync byte inside a frame is plain data
   always_comb begin
      phase_in = phase_ff;
      lines_in = lines_ff;
      if (s1_adv) begin
         case (phase_ff)
            PH_HIGH:  phase_in = PH_LOW;
            PH_LOW:   phase_in = PH_CHECK;
            PH_CHECK: phase_in = PH_TRAIL;
            PH_TRAIL: begin
               phase_in = PH_IDLE;
               lines_in = lines_ff ^ dec.toggle;
            end
            default:  phase_in = (s1_byte_ff == cfg_ff.sync) ? PH_HIGH : PH_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (load_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_vld_in = 1'b0;
      end
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync    <= SYNC_RST;
         cfg_ff.trailer <= TRAILER_RST;
         cfg_ff.code[0] <= CODE1_RST;
         cfg_ff.code[1] <= CODE2_RST;
         cfg_ff.code[2] <= CODE3_RST;
         cfg_ff.code[3] <= CODE4_RST;
         s1_vld_ff      <= 1'b0;
         phase_ff       <= PH_IDLE;
         lines_ff       <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         s1_vld_ff  <= s1_vld_in;
         phase_ff   <= phase_in;
         lines_ff   <= lines_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload: no reset needed, each field is written before it is read
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_ch.rx_byte;
      end
      if (s1_adv && (phase_ff == PH_HIGH)) begin
         high_ff <= s1_byte_ff;
      end
      if (s1_adv && (phase_ff == PH_LOW)) begin
         low_ff <= s1_byte_ff;
      end
      if (s1_adv && (phase_ff == PH_CHECK)) begin
         check_ff <= s1_byte_ff;
      end
      if (load_rsp) begin
         rsp_cmd_ff   <= dec.cmd;
         rsp_ok_ff    <= dec.ok;
         rsp_lines_ff <= lines_in;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.command     = rsp_cmd_ff;
   assign rsp_ch.frame_ok    = rsp_ok_ff;
   assign rsp_ch.line_levels = rsp_lines_ff;

   // ---------------- assertions
   // a failed frame always reports command zero
   a_fail_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ok_ff) |-> (rsp_cmd_ff == '0))
      else $error("failed frame with nonzero command");

   // line levels move only when a result is loaded
   a_lines_on_load: assert property (@(posedge clock) disable iff (reset)
      !$stable(lines_ff) |-> $past(load_rsp))
      else $error("line levels changed without a completed frame");

   // a pending result always shows the live line levels
   a_rsp_lines_live: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_lines_ff == lines_ff))
      else $error("result line levels out of step with lines");

   // a stalled trailer byte never gets overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_adv) |=> (s1_vld_ff && $stable(s1_byte_ff)))
      else $error("input register overwritten while stalled");

endmodule
